FILE: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/upd_pkg.sv
// Package for the URL percent decoder: character codes, types, hex helper.
`default_nettype none
package upd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam int unsigned HexRadixBits = 4;  // radix 16: high digit shifts by one nibble

  localparam int unsigned MaxRes  = 3;  // results one input byte can cause
  localparam int unsigned QDepth  = 4;  // output queue entries
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Escape tracking, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,  // no escape pending
    PH_PCT  = 3'b010,  // '%' held
    PH_DIG  = 3'b100   // '%' and one hex digit held
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0]        n;        // number of valid results
    res_t [MaxRes-1:0] r;        // r[0] goes out first
    phase_e            phase_nxt;
    logic              hold_ld;  // capture the input byte as held digit
  } dec_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/url_percent_decoder.sv
// URL percent decoder: top level with escape state, decode and output queue.
//
// Decodes a percent-encoded byte stream one byte per transaction. '+' becomes a
// space, '%' with two hex digits (either case) becomes the byte they spell, and a
// '%' that is not followed by two hex digits comes out literally, with the bytes
// after it handled afresh. A pending escape is flushed on in_last_i, and the final
// decoded byte of each string carries out_last_o. Throughput is one input byte
// per cycle while in_ready_o is high; results are registered in the output
// queue. A single input can release up to three bytes (broken escape); these
// drain from a four-entry output queue at one byte per cycle while out_ready_i
// is high. in_ready_o is low while that queue holds two or more bytes and depends
// only on registered queue occupancy, never combinationally on out_ready_i.
`default_nettype none
module url_percent_decoder import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  dec_t       dec;
  logic       in_acc;
  res_t       head;

  assign in_acc = in_valid_i && in_ready_o;

  // Per-byte decode against the current escape state.
  upd_decode u_decode (
    .phase_i (phase_q),
    .held_i  (held_q),
    .byte_i  (in_byte_i),
    .last_i  (in_last_i),
    .dec_o   (dec)
  );

  // Escape state advances only on an accepted transaction.
  assign phase_d = in_acc ? dec.phase_nxt : phase_q;
  assign held_d  = (in_acc && dec.hold_ld) ? in_byte_i : held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // Results are queued; the queue is the result register seen by the output side.
  upd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .dec_i       (dec),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (head)
  );

  assign out_byte_o = head.data;
  assign out_last_o = head.last;

endmodule
`default_nettype wire

FILE: rtl/upd_decode.sv
// Combinational decode of one input byte against the escape state.
`default_nettype none
module upd_decode import upd_pkg::*; (
  input  phase_e     phase_i,
  input  logic [7:0] held_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output dec_t       dec_o
);

  logic [4:0] hv, hh;
  logic       f_emit;
  res_t       f_res;
  phase_e     f_phase;
  logic [1:0] pre_n;

  assign hv = hex_val(byte_i);
  assign hh = hex_val(held_i);

  // Handling of a byte with no escape pending.
  always_comb begin
    f_emit  = 1'b1;
    f_res   = '{data: byte_i, last: last_i};
    f_phase = PH_IDLE;
    if (byte_i == CH_PERCENT) begin
      if (last_i) begin
        f_res = '{data: CH_PERCENT, last: 1'b1};
      end else begin
        f_emit  = 1'b0;
        f_phase = PH_PCT;
      end
    end else if (byte_i == CH_PLUS) begin
      f_res = '{data: CH_SPACE, last: last_i};
    end
  end

  always_comb begin
    dec_o           = '0;
    dec_o.phase_nxt = f_phase;
    pre_n           = 2'd0;
    case (phase_i)
      PH_PCT: begin
        if (hv[4] && !last_i) begin
          dec_o.hold_ld   = 1'b1;
          dec_o.phase_nxt = PH_DIG;
          pre_n           = 2'd3;  // marks "no output at all"
        end else begin
          pre_n = 2'd1;
        end
      end
      PH_DIG: begin
        if (hv[4] && hh[4]) begin
          dec_o.phase_nxt = PH_IDLE;
          pre_n           = 2'd3;
          dec_o.n         = 2'd1;
          dec_o.r[0]      = '{data: {hh[3:0], hv[3:0]}, last: last_i};
        end else begin
          pre_n = 2'd2;
        end
      end
      default: pre_n = 2'd0;
    endcase

    case (pre_n)
      2'd0: begin
        dec_o.r[0] = f_res;
        dec_o.n    = {1'b0, f_emit};
      end
      2'd1: begin
        dec_o.r[0] = '{data: CH_PERCENT, last: 1'b0};
        dec_o.r[1] = f_res;
        dec_o.n    = 2'd1 + {1'b0, f_emit};
      end
      2'd2: begin
        dec_o.r[0] = '{data: CH_PERCENT, last: 1'b0};
        dec_o.r[1] = '{data: held_i, last: 1'b0};
        dec_o.r[2] = f_res;
        dec_o.n    = 2'd2 + {1'b0, f_emit};
      end
      default: ;  // escape held or completed: set above
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/upd_out_fifo.sv
// Register queue taking up to three results per cycle, one out per ready cycle.
`default_nettype none
module upd_out_fifo import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dec_t       dec_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] head_q, head_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic [QPtrW-1:0] tail;
  logic [QCntW-1:0] push_n;
  logic             pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[head_q];
  assign pop         = out_valid_o && out_ready_i;
  // room for a worst-case burst
  assign room_o      = (cnt_q <= QCntW'(QDepth - MaxRes));
  assign tail        = head_q + cnt_q[QPtrW-1:0];
  assign push_n      = push_i ? QCntW'(dec_i.n) : '0;

  assign head_d = pop ? head_q + QPtrW'(1) : head_q;
  assign cnt_d  = cnt_q + push_n - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRes; k++) begin
      if (push_i && (k < int'(dec_i.n))) begin
        mem_q[tail + QPtrW'(k)] <= dec_i.r[k];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/upd_checker.sv
// Port-level checker for the URL percent decoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module upd_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_o,
  input  logic       out_last_o
);

  logic unused_in;
  assign unused_in = ^{in_byte_i, in_last_i};

  // A stalled result stays offered.
  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "out_valid dropped while stalled")
  // A stalled result keeps its payload.
  `ASSERT_CLKD(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_byte_o) && $stable(out_last_o), "output payload changed while stalled")
  // Results only appear after an input transaction.
  `ASSERT_CLKD(a_out_cause, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o), "result without input transaction")
  // An empty output side never blocks the input.
  `ASSERT_CLKD(a_ready_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty queue")

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the URL percent decoder: random and directed strings.
`timescale 1ns / 1ps
module tb;
  import upd_pkg::*;

  localparam int unsigned NumDirected = 24;
  localparam int unsigned NumRandom   = 346;
  localparam int unsigned NumItems    = NumDirected + NumRandom;
  localparam int unsigned QuietFrom   = NumItems - 60;  // no idling after this item
  localparam int unsigned StallLimit  = 2000;           // cycles without any transaction
  localparam int unsigned TailCycles  = 8;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned gap;    // idle cycles before this byte is offered
    bit          drain;  // hold off until all decoded bytes are out
  } enc_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  enc_byte_t   raw_q[$];      // encoded bytes waiting to be sent
  res_t        decoded_q[$];  // decoded bytes expected from the block
  int unsigned n_queued = 0;
  int unsigned n_sent = 0;
  int unsigned n_strings = 0;
  int unsigned n_decoded = 0;
  int unsigned n_errors = 0;
  int unsigned stall_cnt = 0;

  // Decoder state mirrored on the testbench side.
  phase_e     esc_phase = PH_IDLE;
  logic [7:0] esc_digit = 8'h00;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  url_percent_decoder i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last)
  );

  // Idling is allowed in two of every three windows of 40 input bytes, never in the tail.
  function automatic bit idle_window(int unsigned k);
    return (k < QuietFrom) && (((k / 40) % 3) != 2);
  endfunction

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Letters have bit 6 set; their low nibble is 1..6 for A..F / a..f.
  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    return c[6] ? c[3:0] + 4'd9 : c[3:0];
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + v[7:0];
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v[7:0] - 8'd10;
  endfunction

  task automatic add_byte(logic [7:0] data, logic last);
    enc_byte_t it;
    it.data  = data;
    it.last  = last;
    it.gap   = (idle_window(n_queued) && $urandom_range(0, 99) < 30) ?
               $urandom_range(1, 12) : 0;
    it.drain = (n_queued % 90) == NumDirected + 1;
    raw_q = {raw_q, it};
    n_queued++;
  endtask

  task automatic expect_byte(logic [7:0] data, logic last);
    res_t r;
    r.data = data;
    r.last = last;
    decoded_q = {decoded_q, r};
  endtask

  // Byte seen with no escape pending.
  task automatic decode_plain(logic [7:0] b, logic last);
    esc_phase = PH_IDLE;
    if (b == CH_PERCENT) begin
      if (last) expect_byte(CH_PERCENT, 1'b1);
      else esc_phase = PH_PCT;
    end else if (b == CH_PLUS) begin
      expect_byte(CH_SPACE, last);
    end else begin
      expect_byte(b, last);
    end
  endtask

  // Expected decoder output for one accepted encoded byte.
  task automatic decode_byte(logic [7:0] b, logic last);
    case (esc_phase)
      PH_PCT: begin
        if (is_hex_char(b) && !last) begin
          esc_digit = b;
          esc_phase = PH_DIG;
        end else begin
          // '%' without a digit after it comes out as is
          expect_byte(CH_PERCENT, 1'b0);
          decode_plain(b, last);
        end
      end
      PH_DIG: begin
        if (is_hex_char(b)) begin
          expect_byte({hex_nibble(esc_digit), hex_nibble(b)}, last);
          esc_phase = PH_IDLE;
        end else begin
          // broken escape: flush '%' and the held digit, then treat b afresh
          expect_byte(CH_PERCENT, 1'b0);
          expect_byte(esc_digit, 1'b0);
          decode_plain(b, last);
        end
      end
      default: decode_plain(b, last);
    endcase
  endtask

  // Sender: one nonblocking write per signal per edge.
  int unsigned idle_left = 0;
  bit          gap_armed = 1'b0;

  always @(posedge clk) begin
    logic nxt_valid;
    logic took;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) begin
        decode_byte(in_byte, in_last);
        n_sent++;
        if (in_last) n_strings++;
      end
      nxt_valid = in_valid && !took;
      if (!nxt_valid && raw_q.size() != 0) begin
        if (!gap_armed) begin
          idle_left = raw_q[0].gap;
          gap_armed = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
        end else if (!(raw_q[0].drain && decoded_q.size() != 0)) begin
          in_byte   <= raw_q[0].data;
          in_last   <= raw_q[0].last;
          nxt_valid = 1'b1;
          gap_armed = 1'b0;
          void'(raw_q.pop_front());
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Receiver: checks each output transaction and stalls in bursts.
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    logic nxt_ready;
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_decoded++;
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected output byte %h last %b", $time, out_byte, out_last);
          n_errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
            n_errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
            n_errors++;
          end
        end
      end
      nxt_ready = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (idle_window(n_sent) && $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(1, 12) - 1;
        nxt_ready = 1'b0;
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cnt);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  tok_q[$];
    int unsigned target;
    int unsigned sel;
    int          i;

    // Directed strings: byte extremes, good escapes in both cases, '+',
    // broken escapes (up to three bytes out), escapes cut by end of string,
    // and '%' or '+' right after a broken escape.
    add_byte(8'h00, 1'b0);                                        // 00 FF
    add_byte(8'hFF, 1'b1);
    add_byte("%", 1'b0); add_byte("a", 1'b0);                    // %aF+
    add_byte("F", 1'b0); add_byte("+", 1'b1);
    add_byte("%", 1'b0); add_byte("4", 1'b0); add_byte("+", 1'b0); // %4+%G
    add_byte("%", 1'b0); add_byte("G", 1'b1);
    add_byte("%", 1'b0); add_byte("%", 1'b0); add_byte("9", 1'b1); // %%9
    add_byte("%", 1'b1);                                         // lone %
    add_byte("%", 1'b0); add_byte("7", 1'b1);                    // %7 cut
    add_byte("%", 1'b0); add_byte("3", 1'b0); add_byte("%", 1'b1); // %3%
    add_byte("+", 1'b1);
    add_byte("%", 1'b0); add_byte("0", 1'b0); add_byte("0", 1'b1); // %00

    // Random strings, mostly well-formed escapes mixed with noise.
    while (n_queued < NumItems) begin
      tok_q.delete();
      target = $urandom_range(1, 10);
      while (tok_q.size() < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          tok_q = {tok_q, CH_PERCENT};
          tok_q = {tok_q, rand_hex_char()};
          tok_q = {tok_q, rand_hex_char()};
        end else if (sel < 50) begin
          tok_q = {tok_q, CH_PLUS};
        end else if (sel < 58) begin
          tok_q = {tok_q, CH_PERCENT};
        end else if (sel < 70) begin
          tok_q = {tok_q, CH_PERCENT};
          tok_q = {tok_q, rand_hex_char()};
        end else if (sel < 78) begin
          tok_q = {tok_q, rand_hex_char()};
        end else begin
          tok_q = {tok_q, 8'($urandom_range(0, 255))};
        end
      end
      for (i = 0; i < tok_q.size(); i++) add_byte(tok_q[i], i == tok_q.size() - 1);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (n_sent < n_queued) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (decoded_q.size() != 0) begin
      $display("%0t: %0d decoded bytes never arrived", $time, decoded_q.size());
      n_errors++;
    end
    $display("Sent %0d encoded bytes in %0d strings, checked %0d decoded bytes,",
             n_sent, n_strings, n_decoded);
    $display("with idle bursts on both sides and a drained pause; %0d mismatches.", n_errors);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
